>>> src/tcp_pkg.sv
// Shared constants and types of the text console put-char engine.
`default_nettype none
package tcp_pkg;

	localparam int MAX_COLS   = 128;
	localparam int MAX_ROWS   = 64;
	localparam int CELL_COUNT = 8192;
	localparam int LA_W       = 14;

	localparam logic [15:0] BLANK_CELL   = 16'h0720;
	localparam logic [7:0]  NEWLINE_CODE = 8'h0a;

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_ATTR   = 2'd2;

	typedef enum logic [4:0] {
		ST_CLEAR  = 5'b00001,
		ST_IDLE   = 5'b00010,
		ST_EXEC   = 5'b00100,
		ST_SCROLL = 5'b01000,
		ST_FIN    = 5'b10000
	} state_t;

	typedef struct packed {
		logic            wr;
		logic [LA_W-1:0] addr;
		logic [6:0]      col;
		logic [5:0]      row;
		logic            scroll;
	} put_upd_t;

endpackage
`default_nettype wire

>>> src/text_console_put_char_core.sv
// Text console put-char engine: cell memory, cursor, scroll sweep and handshakes.
//
// Input channel (in_valid/in_ready) takes one word: opcode, char_code, read_index.
// Opcode 0 puts char_code at the cursor (newline moves to the next row), opcode 1
// reads the cell at read_index. Output channel (out_valid/out_ready) returns one
// word per item: cursor after the item, a scroll flag and the cell read (0 on puts).
// Configuration writes (cfg_wen, cfg_index, cfg_data) set width, height and the
// attribute byte; they take effect at once and are meant for idle periods.
// An item is accepted in ST_IDLE; a read or plain put has its result registered in
// ST_EXEC once the output register is free. A put that scrolls walks the memory
// one cell per cycle through the single read and write port pair: each cell of
// rows 1 and up is copied one row up, the last row is filled with blanks, and the
// result is then registered in ST_FIN once the output register is free.
// After reset a clearing pass writes blank cells to all CELL_COUNT entries, one per
// cycle; in_ready stays low until the pass ends.
// When the receiver stalls, the result waits in the output register; the next
// item can still be accepted and is held until the output register frees up.
`default_nettype none
module text_console_put_char_core #(
	parameter int CELL_COUNT = tcp_pkg::CELL_COUNT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        opcode,
	input  logic [7:0]  char_code,
	input  logic [12:0] read_index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [6:0]  cursor_col,
	output logic [5:0]  cursor_row,
	output logic        scrolled,
	output logic [15:0] cell_value,
	input  logic        cfg_wen,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	import tcp_pkg::*;

	localparam int AW = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
	localparam logic [AW-1:0] CLR_LAST = AW'(CELL_COUNT - 1);

	state_t state_q;

	logic [7:0]      width_q;
	logic [6:0]      height_q;
	logic [7:0]      attr_q;
	logic [LA_W-1:0] lim_copy_q;
	logic [LA_W-1:0] lim_end_q;

	logic [6:0] cur_col_q;
	logic [5:0] cur_row_q;

	logic       op_q;
	logic [7:0] ch_q;
	logic       rd_oob_q;

	logic [AW-1:0]   clr_q;
	logic [LA_W-1:0] k_q;
	logic            valid_s1;
	logic [LA_W-1:0] k_s1;
	logic            copy_s1;
	logic            src_ok_s1;

	logic        out_valid_q;
	logic [6:0]  out_col_q;
	logic [5:0]  out_row_q;
	logic        out_scr_q;
	logic [15:0] out_cell_q;

	put_upd_t        upd;
	logic            slot_free;
	logic            accept;
	logic            issue;
	logic            copy;
	logic [LA_W-1:0] src;
	logic            src_ok;
	logic            put_ok;
	logic            commit;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [15:0]   mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	logic [15:0]   mem_rdata;

	tcp_cursor u_cursor (
		.cur_col   (cur_col_q),
		.cur_row   (cur_row_q),
		.width     (width_q),
		.height    (height_q),
		.char_code (ch_q),
		.upd       (upd)
	);

	tcp_cell_ram #(
		.DEPTH (CELL_COUNT),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign in_ready   = (state_q == ST_IDLE);
	assign accept     = in_valid && in_ready;
	assign slot_free  = !out_valid_q || out_ready;
	assign issue      = (state_q == ST_SCROLL) && (k_q < lim_end_q);
	assign copy       = (k_q < lim_copy_q);
	assign src        = k_q + LA_W'(width_q);
	assign src_ok     = (32'(src) < 32'(CELL_COUNT));
	assign put_ok     = upd.wr && (32'(upd.addr) < 32'(CELL_COUNT));
	assign commit     = (state_q == ST_EXEC) && !op_q && (slot_free || upd.scroll);

	assign out_valid  = out_valid_q;
	assign cursor_col = out_col_q;
	assign cursor_row = out_row_q;
	assign scrolled   = out_scr_q;
	assign cell_value = out_cell_q;

	// memory port selection
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = clr_q;
		mem_wdata = BLANK_CELL;
		if (state_q == ST_CLEAR) begin
			mem_we = 1'b1;
		end else if (commit) begin
			mem_we    = put_ok;
			mem_waddr = AW'(upd.addr);
			mem_wdata = {attr_q, ch_q};
		end else if (valid_s1) begin
			mem_we    = (32'(k_s1) < 32'(CELL_COUNT));
			mem_waddr = AW'(k_s1);
			mem_wdata = !copy_s1 ? BLANK_CELL : (src_ok_s1 ? mem_rdata : 16'h0000);
		end

		mem_re    = 1'b0;
		mem_raddr = AW'(read_index);
		if (accept) begin
			mem_re = opcode && (32'(read_index) < 32'(CELL_COUNT));
		end else if (issue) begin
			mem_re    = copy && src_ok;
			mem_raddr = AW'(src);
		end
	end

	// configuration registers, width and height stored clamped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 8'd80;
			height_q <= 7'd25;
			attr_q   <= 8'd7;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_WIDTH: begin
					if (cfg_data == 8'd0) width_q <= 8'd1;
					else if (cfg_data > 8'(MAX_COLS)) width_q <= 8'(MAX_COLS);
					else width_q <= cfg_data;
				end
				REG_HEIGHT: begin
					if (cfg_data[6:0] == 7'd0) height_q <= 7'd1;
					else if (cfg_data[6:0] > 7'(MAX_ROWS)) height_q <= 7'(MAX_ROWS);
					else height_q <= cfg_data[6:0];
				end
				REG_ATTR: attr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		lim_copy_q <= LA_W'(width_q) * LA_W'(height_q - 7'd1);
		lim_end_q  <= LA_W'(width_q) * LA_W'(height_q);
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= opcode;
			ch_q     <= char_code;
			rd_oob_q <= (32'(read_index) >= 32'(CELL_COUNT));
		end
		k_s1      <= k_q;
		copy_s1   <= copy;
		src_ok_s1 <= src_ok;
		if (state_q == ST_EXEC) begin
			k_q <= '0;
		end else if (issue) begin
			k_q <= k_q + LA_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			cur_col_q   <= '0;
			cur_row_q   <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1 <= issue;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == CLR_LAST) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (accept) state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (op_q) begin
						if (slot_free) begin
							out_valid_q <= 1'b1;
							out_col_q   <= cur_col_q;
							out_row_q   <= cur_row_q;
							out_scr_q   <= 1'b0;
							out_cell_q  <= rd_oob_q ? 16'h0000 : mem_rdata;
							state_q     <= ST_IDLE;
						end
					end else if (commit) begin
						cur_col_q <= upd.col;
						cur_row_q <= upd.row;
						if (upd.scroll) begin
							state_q <= ST_SCROLL;
						end else begin
							out_valid_q <= 1'b1;
							out_col_q   <= upd.col;
							out_row_q   <= upd.row;
							out_scr_q   <= 1'b0;
							out_cell_q  <= 16'h0000;
							state_q     <= ST_IDLE;
						end
					end
				end
				ST_SCROLL: begin
					if (!issue && !valid_s1) state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						out_col_q   <= cur_col_q;
						out_row_q   <= cur_row_q;
						out_scr_q   <= 1'b1;
						out_cell_q  <= 16'h0000;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_CLEAR;
			endcase
		end
	end

endmodule
`default_nettype wire

>>> src/tcp_cell_ram.sv
// Cell memory: one write port, one registered read port.
`default_nettype none
module tcp_cell_ram #(
	parameter int DEPTH = tcp_pkg::CELL_COUNT,
	parameter int AW    = 13
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [15:0]   wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [15:0]   rdata
);
	import tcp_pkg::*;

	logic [15:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

>>> src/tcp_cursor.sv
// Cursor advance, line feed and scroll decision for one put.
`default_nettype none
module tcp_cursor (
	input  logic [6:0]        cur_col,
	input  logic [5:0]        cur_row,
	input  logic [7:0]        width,
	input  logic [6:0]        height,
	input  logic [7:0]        char_code,
	output tcp_pkg::put_upd_t upd
);
	import tcp_pkg::*;

	logic [LA_W-1:0] base;
	logic [7:0]      col_inc;
	logic [6:0]      row_inc;
	logic            is_nl;
	logic            feed;

	always_comb begin
		base    = LA_W'(cur_row) * LA_W'(width);
		is_nl   = (char_code == NEWLINE_CODE);
		col_inc = {1'b0, cur_col} + 8'd1;
		row_inc = {1'b0, cur_row} + 7'd1;
		feed    = is_nl || (col_inc >= width);

		upd.wr     = !is_nl;
		upd.addr   = base + LA_W'(cur_col);
		upd.col    = cur_col;
		upd.row    = cur_row;
		upd.scroll = 1'b0;
		if (!feed) begin
			upd.col = col_inc[6:0];
		end else if (row_inc < height) begin
			upd.col = '0;
			upd.row = row_inc[5:0];
		end else begin
			upd.col    = '0;
			upd.row    = 6'(height - 7'd1);
			upd.scroll = 1'b1;
		end
	end

endmodule
`default_nettype wire

>>> src/tcp_checker.sv
// Port-level checks of the text console engine, bound to the top level.
`default_nettype none
module tcp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [6:0]  cursor_col,
	input logic [5:0]  cursor_row,
	input logic        scrolled,
	input logic [15:0] cell_value
);

	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !in_ready && !out_valid)
		else $error("ready or valid during reset");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second word taken while one is in work");

	a_scroll_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && scrolled |-> cursor_col == 7'd0 && cell_value == 16'h0000)
		else $error("scroll result with bad cursor or cell");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(cell_value)
			&& $stable(cursor_col) && $stable(cursor_row) && $stable(scrolled))
		else $error("stalled result word changed");

endmodule

bind text_console_put_char_core tcp_checker u_tcp_checker (.*);
`default_nettype wire
